>>> design/lmrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrr_pkg
// Shared codes, register addresses and controller command type for the
// LED matrix row refresh core.
// ----------------------------------------------------------------------------
package lmrr_pkg;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_REFRESH = 2'd1;
  localparam logic [1:0] FUNC_INIT    = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCANLIMIT = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;

  localparam logic [7:0] SHUTDOWN_NORMAL = 8'h01;
  localparam logic [7:0] DECODE_NONE     = 8'h00;

  localparam logic [2:0] ROW_LAST   = 3'd7;
  localparam logic [2:0] GROUP_LAST = 3'd3;

  localparam logic [1:0] GRP_SHUTDOWN  = 2'd0;
  localparam logic [1:0] GRP_INTENSITY = 2'd1;
  localparam logic [1:0] GRP_SCANLIMIT = 2'd2;
  localparam logic [1:0] GRP_DECODE    = 2'd3;

  localparam logic CFG_INTENSITY  = 1'b0;
  localparam logic CFG_SCAN_LIMIT = 1'b1;

  typedef struct packed {
    logic       wr;
    logic       clr;
    logic       fetch;
    logic       emit;
    logic       init;
    logic [2:0] row;
    logic [2:0] dev;
    logic       latch;
    logic       last;
  } cmd_t;

  function automatic logic [3:0] init_addr(input logic [1:0] grp);
    logic [3:0] a;
    unique case (grp)
      GRP_SHUTDOWN:  a = REG_SHUTDOWN;
      GRP_INTENSITY: a = REG_INTENSITY;
      GRP_SCANLIMIT: a = REG_SCANLIMIT;
      default:       a = REG_DECODE;
    endcase
    return a;
  endfunction

endpackage

>>> design/led_matrix_row_refresh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_row_refresh_core
// Column store and register-word sequencer for a chain of 8x8 LED matrix
// drivers, with an APB-style register port for intensity and scan limit.
// ----------------------------------------------------------------------------
// Write and clear words are taken while the core is idle and produce no
// output. A refresh word produces 8*SEGMENTS register words and an init word
// 4*SEGMENTS, highest device first, one per cycle while out_ready is high;
// such an item holds in_ready low until its last word has been loaded into
// the output register, so no new word is taken during a sequence. The first
// device's columns are read into the read stage before the first word is
// formed, and the sequence waits while the output register is full and
// out_ready is low. The last word waits in the output register while the
// next input word is taken.
module led_matrix_row_refresh_core #(
  parameter int SEGMENTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_column_index,
  input  logic [7:0]  in_column_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_reg_address,
  output logic [7:0]  out_reg_data,
  output logic [2:0]  out_device_index,
  output logic        out_latch,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0] intensity_r;
  logic [2:0] scan_limit_r;
  logic       cfg_wr;
  logic       out_free;

  lmrr_pkg::cmd_t cmd;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r  <= 4'd0;
      scan_limit_r <= 3'd7;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == lmrr_pkg::CFG_INTENSITY) begin
        intensity_r <= cfg_pwdata[3:0];
      end else begin
        scan_limit_r <= cfg_pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == lmrr_pkg::CFG_SCAN_LIMIT) begin
      cfg_prdata = {29'd0, scan_limit_r};
    end else begin
      cfg_prdata = {28'd0, intensity_r};
    end
  end

  lmrr_ctrl #(
    .SEGMENTS (SEGMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  lmrr_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_column_index  (in_column_index),
    .in_column_bits   (in_column_bits),
    .intensity        (intensity_r),
    .scan_limit       (scan_limit_r),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reg_address  (out_reg_address),
    .out_reg_data     (out_reg_data),
    .out_device_index (out_device_index),
    .out_latch        (out_latch),
    .out_last         (out_last)
  );

endmodule

>>> design/lmrr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrr_ctrl
// Sequencer: takes items, walks rows/groups and devices, issues fetch and
// emit commands to the datapath.
// ----------------------------------------------------------------------------
module lmrr_ctrl #(
  parameter int SEGMENTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  input  logic              out_free,
  output lmrr_pkg::cmd_t    cmd
);

  localparam logic [2:0] DEV_TOP = 3'(SEGMENTS - 1);

  typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

  state_t     state_r;
  logic       mode_init_r;
  logic       fin_r;
  logic [2:0] row_r;
  logic [2:0] dev_r;

  logic       idle;
  logic       start;
  logic       cur_init;
  logic [2:0] cur_row;
  logic [2:0] cur_dev;
  logic [2:0] row_max;
  logic       desc_latch;
  logic       desc_last;
  logic       step;

  always_comb begin
    idle       = (state_r == ST_IDLE);
    start      = idle && in_valid &&
                 (in_func == lmrr_pkg::FUNC_REFRESH || in_func == lmrr_pkg::FUNC_INIT);
    cur_init   = idle ? (in_func == lmrr_pkg::FUNC_INIT) : mode_init_r;
    cur_row    = idle ? 3'd0 : row_r;
    cur_dev    = idle ? DEV_TOP : dev_r;
    row_max    = cur_init ? lmrr_pkg::GROUP_LAST : lmrr_pkg::ROW_LAST;
    desc_latch = (cur_dev == 3'd0);
    desc_last  = desc_latch && (cur_row == row_max);
    step       = start || (!idle && out_free && !fin_r);

    in_ready   = idle;
    cmd        = '0;
    cmd.wr     = idle && in_valid && (in_func == lmrr_pkg::FUNC_WRITE);
    cmd.clr    = idle && in_valid && (in_func == lmrr_pkg::FUNC_CLEAR);
    cmd.emit   = !idle && out_free;
    cmd.fetch  = step;
    cmd.init   = cur_init;
    cmd.row    = cur_row;
    cmd.dev    = cur_dev;
    cmd.latch  = desc_latch;
    cmd.last   = desc_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_init_r <= 1'b0;
      fin_r       <= 1'b0;
      row_r       <= 3'd0;
      dev_r       <= 3'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r     <= ST_RUN;
            mode_init_r <= cur_init;
          end
        end
        ST_RUN: begin
          if (out_free && fin_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (step) begin
        fin_r <= desc_last;
        if (desc_latch) begin
          dev_r <= DEV_TOP;
          row_r <= cur_row + 3'd1;
        end else begin
          dev_r <= cur_dev - 3'd1;
          row_r <= cur_row;
        end
      end
    end
  end

endmodule

>>> design/lmrr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrr_dp
// Column memory with per-column valid bits, device-row read stage,
// transpose and the output word register.
// ----------------------------------------------------------------------------
module lmrr_dp #(
  parameter int SEGMENTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lmrr_pkg::cmd_t    cmd,
  input  logic [5:0]        in_column_index,
  input  logic [7:0]        in_column_bits,
  input  logic [3:0]        intensity,
  input  logic [2:0]        scan_limit,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_reg_address,
  output logic [7:0]        out_reg_data,
  output logic [2:0]        out_device_index,
  output logic              out_latch,
  output logic              out_last
);

  localparam int DEV_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [6:0] NCOLS = 7'(SEGMENTS * 8);

  logic [7:0] mem_r [SEGMENTS][8];
  logic [7:0] vld_r [SEGMENTS];

  logic [7:0] rd_data_r [8];
  logic [7:0] rd_vld_r;
  logic       rd_init_r;
  logic [2:0] rd_row_r;
  logic [2:0] rd_dev_r;
  logic       rd_latch_r;
  logic       rd_last_r;

  logic       out_valid_r;
  logic [3:0] out_addr_r;
  logic [7:0] out_data_r;
  logic [2:0] out_dev_r;
  logic       out_latch_r;
  logic       out_last_r;

  logic             wr_hit;
  logic [DEV_W-1:0] wr_row;
  logic [2:0]       wr_col;
  logic [DEV_W-1:0] rd_addr;
  logic [7:0]       row_byte;
  logic [7:0]       init_data;
  logic [3:0]       word_addr;
  logic [7:0]       word_data;

  always_comb begin
    wr_hit  = ({1'b0, in_column_index} < NCOLS);
    wr_row  = in_column_index[3 +: DEV_W];
    wr_col  = in_column_index[2:0];
    rd_addr = cmd.dev[DEV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_hit) begin
      mem_r[wr_row][wr_col] <= in_column_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        vld_r[i] <= 8'd0;
      end
    end else if (cmd.clr) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        vld_r[i] <= 8'd0;
      end
    end else if (cmd.wr && wr_hit) begin
      vld_r[wr_row][wr_col] <= 1'b1;
    end
  end

  // one device's eight columns per fetch
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data_r  <= mem_r[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
      rd_init_r  <= cmd.init;
      rd_row_r   <= cmd.row;
      rd_dev_r   <= cmd.dev;
      rd_latch_r <= cmd.latch;
      rd_last_r  <= cmd.last;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      row_byte[b] = rd_vld_r[b] & rd_data_r[b][rd_row_r];
    end
    unique case (rd_row_r[1:0])
      lmrr_pkg::GRP_SHUTDOWN:  init_data = lmrr_pkg::SHUTDOWN_NORMAL;
      lmrr_pkg::GRP_INTENSITY: init_data = {4'd0, intensity};
      lmrr_pkg::GRP_SCANLIMIT: init_data = {5'd0, scan_limit};
      default:                 init_data = lmrr_pkg::DECODE_NONE;
    endcase
    word_addr = rd_init_r ? lmrr_pkg::init_addr(rd_row_r[1:0]) : ({1'b0, rd_row_r} + 4'd1);
    word_data = rd_init_r ? init_data : row_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_addr_r  <= word_addr;
      out_data_r  <= word_data;
      out_dev_r   <= rd_dev_r;
      out_latch_r <= rd_latch_r;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_free         = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_reg_address  = out_addr_r;
  assign out_reg_data     = out_data_r;
  assign out_device_index = out_dev_r;
  assign out_latch        = out_latch_r;
  assign out_last         = out_last_r;

endmodule

>>> design/lmrr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrr_chk
// Port-level checks for the LED matrix row refresh core.
// ----------------------------------------------------------------------------
module lmrr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_reg_data,
  input logic [2:0] out_device_index,
  input logic       out_latch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reg_data) &&
                                $stable(out_device_index))
    else $error("output word changed while stalled");

  a_latch_dev0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latch == (out_device_index == 3'd0)))
    else $error("latch not on the lowest device");

  a_quiet_items: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    (in_func == lmrr_pkg::FUNC_WRITE || in_func == lmrr_pkg::FUNC_CLEAR) |=> !out_valid)
    else $error("write or clear produced a word");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_func == lmrr_pkg::FUNC_REFRESH || in_func == lmrr_pkg::FUNC_INIT) |=> !in_ready)
    else $error("new word taken during a sequence");

endmodule

bind led_matrix_row_refresh_core lmrr_chk u_lmrr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_func          (in_func),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_reg_data     (out_reg_data),
  .out_device_index (out_device_index),
  .out_latch        (out_latch)
);

>>> test/led_matrix_row_refresh_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_row_refresh_core_tb
// Checks the column store, row transpose and init sequencing of the core.
// Words go in over a valid/ready port with random gaps. Register words come
// back under random backpressure and one long output stall. Each register
// word is checked, field by field, against a model of the chain kept in the
// bench. Intensity and scan limit are changed over the APB port between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module led_matrix_row_refresh_core_tb;

  localparam int SEG          = 4;
  localparam int NCOLS        = SEG * 8;
  localparam int DRAIN_CYCLES = 8 * SEG + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RUN_LIMIT_NS = 3_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0] ADDR_INTENSITY  = 3'(4 * lmrr_pkg::CFG_INTENSITY);
  localparam logic [2:0] ADDR_SCAN_LIMIT = 3'(4 * lmrr_pkg::CFG_SCAN_LIMIT);

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic [2:0] dev;
    logic       latch;
    logic       last;
  } led_word_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func         = lmrr_pkg::FUNC_WRITE;
  logic [5:0]  in_column_index = '0;
  logic [7:0]  in_column_bits  = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [3:0]  out_reg_address;
  logic [7:0]  out_reg_data;
  logic [2:0]  out_device_index;
  logic        out_latch;
  logic        out_last;
  logic        cfg_psel        = 1'b0;
  logic        cfg_penable     = 1'b0;
  logic        cfg_pwrite      = 1'b0;
  logic [2:0]  cfg_paddr       = '0;
  logic [31:0] cfg_pwdata      = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // bench copy of the chain
  logic [7:0] col_mem [NCOLS];
  logic [3:0] bright;
  logic [2:0] scan_rows;
  led_word_t  pending_words [$];

  int   mismatches  = 0;
  logic tx_idle_en  = 1'b1;
  logic rx_idle_en  = 1'b1;
  logic rx_hold_req = 1'b0;

  led_matrix_row_refresh_core #(.SEGMENTS(SEG)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_column_index  (in_column_index),
    .in_column_bits   (in_column_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reg_address  (out_reg_address),
    .out_reg_data     (out_reg_data),
    .out_device_index (out_device_index),
    .out_latch        (out_latch),
    .out_last         (out_last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("led_matrix_row_refresh_core regression: fail");
    $finish;
  end

  task automatic model_reset();
    int i;
    for (i = 0; i < NCOLS; i++) col_mem[i] = '0;
    bright    = 4'd0;
    scan_rows = 3'd7;
  endtask

  // update the column store and queue the register words an item produces
  task automatic predict_item(input logic [1:0] func, input logic [5:0] idx,
                              input logic [7:0] bits);
    int        r;
    int        s;
    int        b;
    int        g;
    led_word_t w;
    case (func)
      lmrr_pkg::FUNC_WRITE: begin
        if (idx < NCOLS) col_mem[idx] = bits;
      end
      lmrr_pkg::FUNC_CLEAR: begin
        for (r = 0; r < NCOLS; r++) col_mem[r] = '0;
      end
      lmrr_pkg::FUNC_REFRESH: begin
        for (r = 0; r < 8; r++) begin
          for (s = SEG - 1; s >= 0; s--) begin
            w.addr = 4'(r + 1);
            for (b = 0; b < 8; b++) w.data[b] = col_mem[s * 8 + b][r];
            w.dev   = 3'(s);
            w.latch = (s == 0);
            w.last  = (r == 7) && (s == 0);
            pending_words.push_back(w);
          end
        end
      end
      default: begin
        for (g = 0; g < 4; g++) begin
          case (2'(g))
            lmrr_pkg::GRP_SHUTDOWN: begin
              w.addr = lmrr_pkg::REG_SHUTDOWN;
              w.data = lmrr_pkg::SHUTDOWN_NORMAL;
            end
            lmrr_pkg::GRP_INTENSITY: begin
              w.addr = lmrr_pkg::REG_INTENSITY;
              w.data = {4'd0, bright};
            end
            lmrr_pkg::GRP_SCANLIMIT: begin
              w.addr = lmrr_pkg::REG_SCANLIMIT;
              w.data = {5'd0, scan_rows};
            end
            default: begin
              w.addr = lmrr_pkg::REG_DECODE;
              w.data = lmrr_pkg::DECODE_NONE;
            end
          endcase
          for (s = SEG - 1; s >= 0; s--) begin
            w.dev   = 3'(s);
            w.latch = (s == 0);
            w.last  = (g == 3) && (s == 0);
            pending_words.push_back(w);
          end
        end
      end
    endcase
  endtask

  // called right after a rising edge; valid stays up across back-to-back words
  task automatic send_word(input logic [1:0] func, input logic [5:0] idx,
                           input logic [7:0] bits);
    if (tx_idle_en && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 12);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_column_index <= idx;
    in_column_bits  <= bits;
    do @(posedge clk); while (!in_ready);
    predict_item(func, idx, bits);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_INTENSITY) bright = value[3:0];
    else if (addr == ADDR_SCAN_LIMIT) scan_rows = value[2:0];
  endtask

  task automatic set_config(input logic [3:0] lvl, input logic [2:0] rows);
    write_reg(ADDR_INTENSITY, {4'($urandom_range(0, 15)), 24'd0, lvl});
    write_reg(ADDR_SCAN_LIMIT, {4'($urandom_range(0, 15)), 25'd0, rows});
  endtask

  // output side
  initial begin : rx_pacing
    int held;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ready <= !rx_idle_en || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    led_word_t want;
    led_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_reg_address, out_reg_data, out_device_index, out_latch, out_last};
      if (pending_words.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected word addr=%h data=%h dev=%0d latch=%b last=%b",
                   $realtime, got.addr, got.data, got.dev, got.latch, got.last);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got.addr !== want.addr || got.data !== want.data || got.dev !== want.dev ||
            got.latch !== want.latch || got.last !== want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: word mismatch exp addr=%h data=%h dev=%0d latch=%b last=%b",
                     $realtime, want.addr, want.data, want.dev, want.latch, want.last,
                     " got addr=%h data=%h dev=%0d latch=%b last=%b",
                     got.addr, got.data, got.dev, got.latch, got.last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_word(lmrr_pkg::FUNC_REFRESH, 6'd0, 8'd0);
    send_word(lmrr_pkg::FUNC_INIT, 6'd0, 8'd0);
    drain();
  endtask

  task automatic test_column_writes();
    send_word(lmrr_pkg::FUNC_WRITE, 6'd0, 8'hFF);
    send_word(lmrr_pkg::FUNC_WRITE, 6'(NCOLS - 1), 8'h80);
    send_word(lmrr_pkg::FUNC_WRITE, 6'd7, 8'h01);
    send_word(lmrr_pkg::FUNC_WRITE, 6'd8, 8'hAA);
    send_word(lmrr_pkg::FUNC_WRITE, 6'd17, 8'h55);
    send_word(lmrr_pkg::FUNC_WRITE, 6'(NCOLS), 8'hFF);
    send_word(lmrr_pkg::FUNC_WRITE, 6'd63, 8'h3C);
    send_word(lmrr_pkg::FUNC_WRITE, 6'd42, 8'h00);
    send_word(lmrr_pkg::FUNC_REFRESH, 6'd63, 8'hFF);
  endtask

  task automatic test_clear();
    send_word(lmrr_pkg::FUNC_CLEAR, 6'($urandom), 8'($urandom));
    send_word(lmrr_pkg::FUNC_REFRESH, 6'($urandom), 8'($urandom));
  endtask

  task automatic test_unused_operands();
    send_word(lmrr_pkg::FUNC_WRITE, 6'd3, 8'h96);
    send_word(lmrr_pkg::FUNC_REFRESH, 6'd3, 8'h00);
    send_word(lmrr_pkg::FUNC_INIT, 6'd63, 8'hFF);
    drain();
  endtask

  task automatic test_config_extremes();
    set_config(4'd15, 3'd0);
    send_word(lmrr_pkg::FUNC_INIT, 6'($urandom), 8'($urandom));
    drain();
    set_config(4'd0, 3'd7);
    send_word(lmrr_pkg::FUNC_INIT, 6'($urandom), 8'($urandom));
    drain();
    set_config(4'd9, 3'd4);
    send_word(lmrr_pkg::FUNC_INIT, 6'($urandom), 8'($urandom));
    drain();
  endtask

  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    send_word(lmrr_pkg::FUNC_WRITE, 6'd12, 8'hC3);
    send_word(lmrr_pkg::FUNC_REFRESH, 6'd0, 8'd0);
    send_word(lmrr_pkg::FUNC_WRITE, 6'd5, 8'hA5);
    send_word(lmrr_pkg::FUNC_INIT, 6'd0, 8'd0);
    send_word(lmrr_pkg::FUNC_REFRESH, 6'd0, 8'd0);
    send_word(lmrr_pkg::FUNC_CLEAR, 6'd0, 8'd0);
    drain();
  endtask

  task automatic test_random_traffic(input int n_items);
    int         i;
    int         roll;
    logic [1:0] func;
    logic [5:0] idx;
    for (i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 57) func = lmrr_pkg::FUNC_WRITE;
      else if (roll < 77) func = lmrr_pkg::FUNC_REFRESH;
      else if (roll < 94) func = lmrr_pkg::FUNC_INIT;
      else func = lmrr_pkg::FUNC_CLEAR;
      if ($urandom_range(0, 99) < 85) idx = 6'($urandom_range(0, NCOLS - 1));
      else idx = 6'($urandom_range(NCOLS, 63));
      send_word(func, idx, 8'($urandom));
    end
    drain();
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_column_writes();
    test_clear();
    test_unused_operands();
    test_config_extremes();
    test_output_stall();

    test_random_traffic(30);
    set_config(4'($urandom), 3'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(25);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    set_config(4'($urandom), 3'($urandom));
    test_random_traffic(30);

    if (mismatches == 0) begin
      $display("led_matrix_row_refresh_core regression: pass");
    end else begin
      $display("led_matrix_row_refresh_core regression: fail");
    end
    $finish;
  end

endmodule
